/* sv/htd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htd_pkg
// shared constants, codes and types of the code-tree decoder
// ----------------------------------------------------------------------------
package htd_pkg;

  // default sizes
  localparam int NODE_COUNT_DEF   = 512;
  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int QUEUE_DEPTH      = 2;

  // fixed field widths
  localparam int CODE_IN_W = 32;
  localparam int LEN_IN_W  = 6;
  localparam int SYM_W     = 8;
  localparam int COUNT_W   = 31;
  localparam int STATUS_W  = 2;

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  // result kinds
  localparam logic KIND_SYMBOL = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // insert status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_COLLISION = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd3;

  // characters
  localparam logic [SYM_W-1:0] CH_HASH  = 8'h23;
  localparam logic [SYM_W-1:0] CH_BAR   = 8'h7C;
  localparam logic [SYM_W-1:0] CH_NL    = 8'h0A;
  localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CH_EMPTY = 8'h00;

  typedef struct packed {
    logic             req_type;
    logic [SYM_W-1:0] symbol;
    logic             stream_bit;
  } cmd_ctl_t;

  typedef struct packed {
    logic                kind;
    logic [SYM_W-1:0]    symbol;
    logic [STATUS_W-1:0] status;
    logic                last;
  } result_t;

  // hash becomes newline, bar becomes space
  function automatic logic [SYM_W-1:0] map_symbol(input logic [SYM_W-1:0] s);
    logic [SYM_W-1:0] m;
    unique case (s)
      CH_HASH: m = CH_NL;
      CH_BAR:  m = CH_SPACE;
      default: m = s;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

/* sv/htd_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htd_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module htd_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* sv/htd_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htd_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module htd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] head_data,
  output logic                  empty,
  output logic                  full
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign empty     = (count_r == '0);
  assign full      = (count_r == CntW'(DEPTH));
  assign head_data = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* sv/htd_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htd_front
// accepts items, saturates the code length, aligns the code, queues them
// ----------------------------------------------------------------------------
module htd_front #(
  parameter int MAX_CODE_LEN = htd_pkg::MAX_CODE_LEN_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic                              in_req_type,
  input  wire logic [htd_pkg::CODE_IN_W-1:0]     in_code_bits,
  input  wire logic [htd_pkg::LEN_IN_W-1:0]      in_code_len,
  input  wire logic [htd_pkg::SYM_W-1:0]         in_symbol_in,
  input  wire logic                              in_stream_bit,
  input  wire logic                              clear_active,
  input  wire logic                              q_full,
  output logic                                   busy,
  output logic                                   q_push,
  output htd_pkg::cmd_ctl_t                      q_ctl,
  output logic      [$clog2(MAX_CODE_LEN+1)-1:0] q_len,
  output logic      [MAX_CODE_LEN-1:0]           q_code
);

  localparam int LenW  = $clog2(MAX_CODE_LEN + 1);
  localparam int CodeW = (MAX_CODE_LEN > htd_pkg::CODE_IN_W) ? MAX_CODE_LEN
                                                             : htd_pkg::CODE_IN_W;

  logic                valid_r, valid_nxt;
  htd_pkg::cmd_ctl_t   ctl_r;
  logic [LenW-1:0]     len_r;
  logic [MAX_CODE_LEN-1:0] code_r;
  logic                accept;
  logic [CodeW-1:0]    code_wide;
  logic [LenW-1:0]     len_sat;

  assign busy   = clear_active || (valid_r && q_full);
  assign accept = start && !busy;
  assign q_push = valid_r && !q_full;
  assign q_ctl  = ctl_r;
  assign q_len  = len_r;
  assign q_code = code_r;

  // bits above the 32-bit field read as zero
  assign code_wide = CodeW'(in_code_bits);

  always_comb begin
    if (int'(in_code_len) > MAX_CODE_LEN) begin
      len_sat = LenW'(MAX_CODE_LEN);
    end else begin
      len_sat = LenW'(in_code_len);
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctl_r.req_type   <= in_req_type;
      ctl_r.symbol     <= in_symbol_in;
      ctl_r.stream_bit <= in_stream_bit;
      len_r            <= len_sat;
      code_r           <= code_wide[MAX_CODE_LEN-1:0];
    end
  end

endmodule
`default_nettype wire

/* sv/htd_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htd_back
// node table, clearing pass, insert walk and decode step sequencer
// ----------------------------------------------------------------------------
module htd_back #(
  parameter int NODE_COUNT   = htd_pkg::NODE_COUNT_DEF,
  parameter int MAX_CODE_LEN = htd_pkg::MAX_CODE_LEN_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_empty,
  output logic                                   q_pop,
  input  wire htd_pkg::cmd_ctl_t                 q_ctl,
  input  wire logic [$clog2(MAX_CODE_LEN+1)-1:0] q_len,
  input  wire logic [MAX_CODE_LEN-1:0]           q_code,
  input  wire logic [htd_pkg::COUNT_W-1:0]       symbol_count,
  output logic                                   clear_active,
  output logic                                   res_valid,
  output htd_pkg::result_t                       res
);

  localparam int AW   = $clog2(NODE_COUNT);
  localparam int SW   = htd_pkg::SYM_W;
  localparam int WW   = 2 * AW + SW;
  localparam int LenW = $clog2(MAX_CODE_LEN + 1);
  localparam int IdxW = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
  localparam int CW   = htd_pkg::COUNT_W;

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_INS      = 3'd2;
  localparam logic [2:0] S_DEC_CUR  = 3'd3;
  localparam logic [2:0] S_DEC_LEAF = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [AW:0]       nf_r, nf_nxt;
  logic [AW-1:0]     walk_r, walk_nxt;
  logic              failed_r, failed_nxt;
  logic [CW-1:0]     decoded_r, decoded_nxt;
  logic              res_valid_r, res_valid_nxt;
  htd_pkg::result_t  res_r, res_nxt;

  // payload of the item in work
  logic [AW-1:0]           cur_r, cur_nxt;
  logic [LenW-1:0]         rem_r, rem_nxt;
  logic [MAX_CODE_LEN-1:0] code_r, code_nxt;
  logic [SW-1:0]           sym_r, sym_nxt;
  logic                    bit_r, bit_nxt;

  // node table: {left, right, symbol}
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [WW-1:0] wr_data;
  logic [AW-1:0] rd_addr;
  logic [WW-1:0] rd_data;
  logic [AW-1:0] rd_left, rd_right;
  logic [SW-1:0] rd_sym;

  logic [IdxW-1:0] bit_idx;
  logic            ins_bit;
  logic [AW-1:0]   ins_link, dec_next;
  logic            rd_leaf, last_hit;
  logic [AW-1:0]   nf_link;

  htd_ram #(
    .WIDTH (WW),
    .DEPTH (NODE_COUNT)
  ) u_nodes (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_left  = rd_data[WW-1 -: AW];
  assign rd_right = rd_data[WW-1-AW -: AW];
  assign rd_sym   = rd_data[SW-1:0];
  assign rd_leaf  = (rd_left == '0) && (rd_right == '0);

  assign bit_idx  = IdxW'(rem_r - 1'b1);
  assign ins_bit  = code_r[bit_idx];
  assign ins_link = ins_bit ? rd_right : rd_left;
  assign dec_next = bit_r ? rd_right : rd_left;
  assign nf_link  = nf_r[AW-1:0];
  assign last_hit = ((decoded_r + 1'b1) == symbol_count);

  assign clear_active = (state_r == S_CLEAR);
  assign res_valid    = res_valid_r;
  assign res          = res_r;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    nf_nxt        = nf_r;
    walk_nxt      = walk_r;
    failed_nxt    = failed_r;
    decoded_nxt   = decoded_r;
    res_valid_nxt = 1'b0;
    res_nxt       = res_r;
    cur_nxt       = cur_r;
    rem_nxt       = rem_r;
    code_nxt      = code_r;
    sym_nxt       = sym_r;
    bit_nxt       = bit_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = cur_r;
    wr_data       = '0;
    rd_addr       = walk_r;

    unique case (state_r)
      S_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(NODE_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          code_nxt = q_code;
          rem_nxt  = q_len;
          sym_nxt  = q_ctl.symbol;
          bit_nxt  = q_ctl.stream_bit;
          if (q_ctl.req_type == htd_pkg::REQ_INSERT) begin
            if (failed_r) begin
              res_valid_nxt  = 1'b1;
              res_nxt.kind   = htd_pkg::KIND_STATUS;
              res_nxt.symbol = htd_pkg::CH_EMPTY;
              res_nxt.status = htd_pkg::ST_IGNORED;
              res_nxt.last   = 1'b0;
            end else begin
              cur_nxt   = '0;
              rd_addr   = '0;
              state_nxt = S_INS;
            end
          end else if (decoded_r < symbol_count) begin
            rd_addr   = walk_r;
            state_nxt = S_DEC_CUR;
          end
        end
      end

      S_INS: begin
        if (rem_r == '0) begin
          // end node reached
          res_valid_nxt  = 1'b1;
          res_nxt.kind   = htd_pkg::KIND_STATUS;
          res_nxt.symbol = htd_pkg::CH_EMPTY;
          res_nxt.last   = 1'b0;
          if (rd_sym != htd_pkg::CH_EMPTY) begin
            failed_nxt     = 1'b1;
            res_nxt.status = htd_pkg::ST_COLLISION;
          end else begin
            wr_en          = 1'b1;
            wr_addr        = cur_r;
            wr_data        = {rd_left, rd_right, sym_r};
            res_nxt.status = htd_pkg::ST_OK;
          end
          state_nxt = S_IDLE;
        end else if (ins_link != '0) begin
          cur_nxt = ins_link;
          rd_addr = ins_link;
          rem_nxt = rem_r - 1'b1;
        end else if (nf_r >= (AW + 1)'(NODE_COUNT)) begin
          failed_nxt     = 1'b1;
          res_valid_nxt  = 1'b1;
          res_nxt.kind   = htd_pkg::KIND_STATUS;
          res_nxt.symbol = htd_pkg::CH_EMPTY;
          res_nxt.status = htd_pkg::ST_FULL;
          res_nxt.last   = 1'b0;
          state_nxt      = S_IDLE;
        end else begin
          // new child; its entry is still zero from the clearing pass
          wr_en   = 1'b1;
          wr_addr = cur_r;
          wr_data = ins_bit ? {rd_left, nf_link, rd_sym} : {nf_link, rd_right, rd_sym};
          cur_nxt = nf_link;
          rd_addr = nf_link;
          nf_nxt  = nf_r + 1'b1;
          rem_nxt = rem_r - 1'b1;
        end
      end

      S_DEC_CUR: begin
        if (dec_next != '0) begin
          walk_nxt  = dec_next;
          rd_addr   = dec_next;
          state_nxt = S_DEC_LEAF;
        end else begin
          // no child: stay, emit only if this node is a leaf
          if (rd_leaf) begin
            res_valid_nxt  = 1'b1;
            res_nxt.kind   = htd_pkg::KIND_SYMBOL;
            res_nxt.symbol = htd_pkg::map_symbol(rd_sym);
            res_nxt.status = htd_pkg::ST_OK;
            res_nxt.last   = last_hit;
            walk_nxt       = '0;
            decoded_nxt    = decoded_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end

      S_DEC_LEAF: begin
        if (rd_leaf) begin
          res_valid_nxt  = 1'b1;
          res_nxt.kind   = htd_pkg::KIND_SYMBOL;
          res_nxt.symbol = htd_pkg::map_symbol(rd_sym);
          res_nxt.status = htd_pkg::ST_OK;
          res_nxt.last   = last_hit;
          walk_nxt       = '0;
          decoded_nxt    = decoded_r + 1'b1;
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      nf_r        <= (AW + 1)'(1);
      walk_r      <= '0;
      failed_r    <= 1'b0;
      decoded_r   <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      nf_r        <= nf_nxt;
      walk_r      <= walk_nxt;
      failed_r    <= failed_nxt;
      decoded_r   <= decoded_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    cur_r  <= cur_nxt;
    rem_r  <= rem_nxt;
    code_r <= code_nxt;
    sym_r  <= sym_nxt;
    bit_r  <= bit_nxt;
  end

endmodule
`default_nettype wire

/* sv/huffman_tree_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_tree_decoder
// code tree builder and bit-serial tree-walk decoder
//
//   channel  handshake              payload
//   -------  ---------------------  ------------------------------------------
//   input    start & !busy          in_req_type in_code_bits in_code_len
//                                   in_symbol_in in_stream_bit
//   result   out_valid (one cycle)  out_result_kind out_symbol_out
//                                   out_insert_status out_last_symbol
//   config   cfg_wr_en              cfg_wr_data (symbol_count)
//
// the front register takes one item a cycle while the queue has room
// back: a decode bit reads the current node, then the child if one is followed;
// a bit past the count is dropped; an insert walks one node per code bit, and
// is ignored after an error; one node-table read port; a full table ends it early
// after reset a clearing pass over all NODE_COUNT entries holds busy high
// the receiver cannot stall; each result is a one-cycle strobe
// ----------------------------------------------------------------------------
module huffman_tree_decoder #(
  parameter int NODE_COUNT   = htd_pkg::NODE_COUNT_DEF,
  parameter int MAX_CODE_LEN = htd_pkg::MAX_CODE_LEN_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input items
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_req_type,
  input  wire logic [htd_pkg::CODE_IN_W-1:0]   in_code_bits,
  input  wire logic [htd_pkg::LEN_IN_W-1:0]    in_code_len,
  input  wire logic [htd_pkg::SYM_W-1:0]       in_symbol_in,
  input  wire logic                            in_stream_bit,
  // symbol_count register
  input  wire logic                            cfg_wr_en,
  input  wire logic [htd_pkg::COUNT_W-1:0]     cfg_wr_data,
  // results
  output logic                                 out_valid,
  output logic                                 out_result_kind,
  output logic      [htd_pkg::SYM_W-1:0]       out_symbol_out,
  output logic      [htd_pkg::STATUS_W-1:0]    out_insert_status,
  output logic                                 out_last_symbol
);

  localparam int LenW = $clog2(MAX_CODE_LEN + 1);
  localparam int CtlW = $bits(htd_pkg::cmd_ctl_t);
  localparam int QW   = CtlW + LenW + MAX_CODE_LEN;

  // configuration register
  logic [htd_pkg::COUNT_W-1:0] symbol_count_r;

  // front to queue
  logic                    clear_active;
  logic                    q_full, q_empty, q_push, q_pop;
  htd_pkg::cmd_ctl_t       f_ctl, b_ctl;
  logic [LenW-1:0]         f_len, b_len;
  logic [MAX_CODE_LEN-1:0] f_code, b_code;
  logic [QW-1:0]           q_wdata, q_head;

  // back results
  logic             res_valid;
  htd_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      symbol_count_r <= '0;
    end else if (cfg_wr_en) begin
      symbol_count_r <= cfg_wr_data;
    end
  end

  // front: takes items, saturates the code length and registers them as queue commands
  htd_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_req_type   (in_req_type),
    .in_code_bits  (in_code_bits),
    .in_code_len   (in_code_len),
    .in_symbol_in  (in_symbol_in),
    .in_stream_bit (in_stream_bit),
    .clear_active  (clear_active),
    .q_full        (q_full),
    .busy          (busy),
    .q_push        (q_push),
    .q_ctl         (f_ctl),
    .q_len         (f_len),
    .q_code        (f_code)
  );

  assign q_wdata = {f_ctl, f_len, f_code};

  // command queue lets the front keep taking items while the back walks
  htd_fifo #(
    .WIDTH (QW),
    .DEPTH (htd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head_data (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign b_ctl  = q_head[QW-1 -: CtlW];
  assign b_len  = q_head[MAX_CODE_LEN +: LenW];
  assign b_code = q_head[MAX_CODE_LEN-1:0];

  // back: node table, insert walks and decode steps
  htd_back #(
    .NODE_COUNT   (NODE_COUNT),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_ctl        (b_ctl),
    .q_len        (b_len),
    .q_code       (b_code),
    .symbol_count (symbol_count_r),
    .clear_active (clear_active),
    .res_valid    (res_valid),
    .res          (res)
  );

  // result strobe and payload straight from the back's output register
  assign out_valid         = res_valid;
  assign out_result_kind   = res.kind;
  assign out_symbol_out    = res.symbol;
  assign out_insert_status = res.status;
  assign out_last_symbol   = res.last;

`ifndef SYNTH
  // nothing comes out while the table is being cleared
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_active |-> !out_valid)
    else $error("result during clearing pass");

  // a status result carries no symbol and no last flag
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == htd_pkg::KIND_STATUS) |->
      (out_symbol_out == htd_pkg::CH_EMPTY && !out_last_symbol))
    else $error("status result with symbol payload");

  // the front never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into full queue");
`endif

endmodule
`default_nettype wire
